// ===== src/ctfr_pkg.sv =====
// shared types, constants and the crc-8 byte update for the tracking frame receiver
// no dependencies; imported by every module of the block
package ctfr_pkg;

    localparam int FRAME_LEN  = 24;
    localparam int CNT_W      = 5;
    localparam int BODY_BYTES = 21;   // frame bytes 2..22 travel to the back end
    localparam int OUT_DATA_W = 168;  // 166 bits of fields padded to whole bytes
    localparam int STATUS_W   = 3;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    localparam logic [CNT_W-1:0] CNT_LAST_IDX = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] CNT_OVER     = CNT_W'(FRAME_LEN + 1);

    localparam logic [31:0] RST_STALE_LIMIT = 32'd300;
    localparam logic [7:0]  RST_MAGIC       = 8'hB7;
    localparam logic [7:0]  RST_VERSION     = 8'h02;

    // configuration register indexes
    localparam logic [1:0] REG_STALE_LIMIT = 2'd0;
    localparam logic [1:0] REG_MAGIC       = 2'd1;
    localparam logic [1:0] REG_VERSION     = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUS_ERR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_MAG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_VER  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_CRC  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_STALE    = 3'd6;

    // one classified exchange, handed from front end to back end
    typedef struct packed {
        logic [STATUS_W-1:0]              status;
        logic [31:0]                      now_ms;
        logic [BODY_BYTES-1:0][7:0]       body;   // body[k] is frame byte k+2
    } t_evt;

    // crc-8, poly 0x07, msb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/ctfr_front.sv =====
// front end: byte count, crc, frame byte store and frame classification
// depends on ctfr_pkg
module ctfr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_first,
    input  logic                 i_last,
    input  logic                 i_err,
    input  logic [31:0]          i_now_ms,
    input  logic [7:0]           i_magic,
    input  logic [7:0]           i_version,
    input  logic                 i_q_full,
    output logic                 o_push,
    output ctfr_pkg::t_evt       o_evt
);
    import ctfr_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_store [0:FRAME_LEN-2];

    logic             accept;
    logic [CNT_W-1:0] eff_cnt;
    logic [7:0]       crc_base;
    logic             wr_en;
    logic [STATUS_W-1:0] status;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        eff_cnt  = i_first ? '0 : r_cnt;
        crc_base = i_first ? 8'h00 : r_crc;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        wr_en    = 1'b0;
        if (accept) begin
            if (i_err) begin
                n_cnt = '0;
                n_crc = 8'h00;
            end else begin
                if (eff_cnt < CNT_FULL) begin
                    n_cnt = eff_cnt + 1'b1;
                    if (eff_cnt < CNT_LAST_IDX) begin
                        n_crc = crc8_byte(crc_base, i_byte);
                        wr_en = 1'b1;
                    end else begin
                        n_crc = crc_base;
                    end
                end else begin
                    n_cnt = CNT_OVER;
                    n_crc = crc_base;
                end
                if (i_last) begin
                    n_cnt = '0;
                    n_crc = 8'h00;
                end
            end
        end
    end

    // classification; a full frame has the crc byte as the current beat
    always_comb begin
        if (i_err) begin
            status = ST_BUS_ERR;
        end else if (eff_cnt != CNT_LAST_IDX) begin
            status = ST_BAD_LEN;
        end else if (r_store[0] != i_magic) begin
            status = ST_BAD_MAG;
        end else if (r_store[1] != i_version) begin
            status = ST_BAD_VER;
        end else if (i_byte != crc_base) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_push       = accept && (i_last || i_err);
        o_evt.status = status;
        o_evt.now_ms = i_now_ms;
        for (int k = 0; k < BODY_BYTES; k++) begin
            o_evt.body[k] = r_store[k + 2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_crc <= 8'h00;
        end else begin
            r_cnt <= n_cnt;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[eff_cnt] <= i_byte;
        end
    end

endmodule

// ===== src/ctfr_queue.sv =====
// two-entry queue of classified exchanges between front end and back end
// depends on ctfr_pkg
module ctfr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ctfr_pkg::t_evt  i_evt,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output ctfr_pkg::t_evt  o_evt
);
    import ctfr_pkg::*;

    t_evt       r_mem [0:1];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_evt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

endmodule

// ===== src/ctfr_back.sv =====
// back end: freshness supervision, field decode and the result output register
// depends on ctfr_pkg
module ctfr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    output logic                      o_pop,
    input  ctfr_pkg::t_evt            i_evt,
    input  logic [31:0]               i_stale_limit,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [ctfr_pkg::OUT_DATA_W-1:0] o_data,
    output logic [ctfr_pkg::STATUS_W-1:0]   o_user
);
    import ctfr_pkg::*;

    logic        r_valid;
    logic [OUT_DATA_W-1:0] r_data, n_data;
    logic [STATUS_W-1:0]   r_user, n_user;
    logic        r_fresh, n_fresh;
    logic [15:0] r_last_seq, n_last_seq;
    logic [31:0] r_last_time, n_last_time;

    logic [15:0] seq;
    logic [31:0] age;
    logic        advance;
    logic        out_fresh;

    assign o_pop   = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

    assign seq = {i_evt.body[1], i_evt.body[0]};

    always_comb begin
        n_fresh     = r_fresh;
        n_last_seq  = r_last_seq;
        n_last_time = r_last_time;
        n_user      = i_evt.status;
        advance     = !r_fresh || (seq != r_last_seq);
        age         = i_evt.now_ms - (advance ? i_evt.now_ms : r_last_time);
        if (i_evt.status == ST_OK) begin
            n_last_seq  = advance ? seq : r_last_seq;
            n_last_time = advance ? i_evt.now_ms : r_last_time;
            if (age > i_stale_limit) begin
                n_fresh = 1'b0;
                n_user  = ST_STALE;
            end else begin
                n_fresh = 1'b1;
            end
        end
        out_fresh = n_fresh;

        n_data = '0;
        n_data[0] = out_fresh;
        if (n_user == ST_OK) begin
            n_data[16:1]    = seq;
            n_data[32:17]   = {i_evt.body[3], i_evt.body[2]};
            n_data[37:33]   = i_evt.body[4][4:0];
            n_data[53:38]   = {i_evt.body[6], i_evt.body[5]};
            n_data[69:54]   = {i_evt.body[8], i_evt.body[7]};
            n_data[85:70]   = {i_evt.body[10], i_evt.body[9]};
            n_data[101:86]  = {i_evt.body[12], i_evt.body[11]};
            n_data[117:102] = {i_evt.body[17], i_evt.body[16]};
            n_data[133:118] = {i_evt.body[20], i_evt.body[19]};
            n_data[165:134] = {i_evt.body[18], i_evt.body[15],
                               i_evt.body[14], i_evt.body[13]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_fresh     <= 1'b0;
            r_last_seq  <= 16'h0000;
            r_last_time <= 32'h0000_0000;
        end else begin
            if (o_pop) begin
                r_valid     <= 1'b1;
                r_fresh     <= n_fresh;
                r_last_seq  <= n_last_seq;
                r_last_time <= n_last_time;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_user <= n_user;
        end
    end

endmodule

// ===== src/crc8_tracking_frame_receiver.sv =====
// top level of the tracking frame receiver: configuration registers and the
// front end, queue and back end; depends on ctfr_pkg, ctfr_front, ctfr_queue, ctfr_back
//
// usage
//   s_axis carries one frame byte per beat: tdata holds the byte and the time in ms,
//   tuser marks the first byte of a frame and a failed bus transfer, tlast ends the
//   frame. a beat with tlast or a bus error produces exactly one result on m_axis;
//   other beats produce none.
//   m_axis tuser is the status code, tdata the freshness flag and decoded fields
//   (all decoded fields zero unless the status is ok).
//   throughput: one byte per cycle while s_axis_tready is high; the crc update of a
//   byte is done in the beat's own cycle.
//   path: the result of the closing beat is written into the queue, then moved into
//   the back-end output register, which drives m_axis.
//   stall: results wait in the output register while m_axis_tready is low; up to two
//   more closed frames queue behind it, then s_axis_tready drops until one drains.
//   reset: synchronous, active low; clears byte count, crc, queue, freshness state
//   and loads the registers with stale limit 300 ms, magic 0xb7, version 2.
//   configuration: i_cfg_we writes register i_cfg_idx (0 stale limit, 1 magic,
//   2 version) from i_cfg_data; unknown indexes are ignored; write only when idle.
module crc8_tracking_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // rx_byte[7:0], now_ms[39:8]
    input  logic [1:0]  s_axis_tuser,   // first_byte[0], bus_error[1]
    input  logic        s_axis_tlast,   // last_byte
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fresh_flag[0], vision_sequence[16:1], chassis_sequence[32:17],
    // track_flags[37:33], lateral_error_mm[53:38], heading_error_cdeg[69:54],
    // curvature_milli_per_m[85:70], delta_speed_mmps[101:86],
    // lookahead_mm[117:102], target_x[133:118], frame_stats[165:134], zero pad
    output logic [ctfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [ctfr_pkg::STATUS_W-1:0]   m_axis_tuser   // status[2:0]
);
    import ctfr_pkg::*;

    // configuration registers
    logic [31:0] r_stale_limit;
    logic [7:0]  r_magic;
    logic [7:0]  r_version;

    // front to queue
    logic q_push;
    t_evt q_in_evt;
    logic q_full;
    // queue to back
    logic q_valid;
    logic q_pop;
    t_evt q_out_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_limit <= RST_STALE_LIMIT;
            r_magic       <= RST_MAGIC;
            r_version     <= RST_VERSION;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STALE_LIMIT: r_stale_limit <= i_cfg_data;
                REG_MAGIC:       r_magic       <= i_cfg_data[7:0];
                REG_VERSION:     r_version     <= i_cfg_data[7:0];
                default: begin
                    // unknown register, write dropped
                end
            endcase
        end
    end

    // byte counting, crc and classification
    ctfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata[7:0]),
        .i_first   (s_axis_tuser[0]),
        .i_last    (s_axis_tlast),
        .i_err     (s_axis_tuser[1]),
        .i_now_ms  (s_axis_tdata[39:8]),
        .i_magic   (r_magic),
        .i_version (r_version),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_evt     (q_in_evt)
    );

    // decouples byte intake from a stalled result consumer
    ctfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_evt   (q_in_evt),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_evt   (q_out_evt)
    );

    // freshness check and result register
    ctfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_pop         (q_pop),
        .i_evt         (q_out_evt),
        .i_stale_limit (r_stale_limit),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_user        (m_axis_tuser)
    );

endmodule
